// ----- rtl/smx_pkg.sv -----
// Shared types and constants for the stack machine executor.
`default_nettype none

package smx_pkg;

   // Data path and stack geometry
   localparam int DATA_W          = 32;
   localparam int STACK_DEPTH_DEF = 256;
   localparam int HDR_W           = 2;
   localparam int PAYLOAD_W       = 30;
   localparam int STATUS_W        = 3;

   // Instruction word fields
   localparam logic [DATA_W-1:0] HDR_MASK     = 32'hc0000000;
   localparam logic [DATA_W-1:0] PAYLOAD_MASK = 32'h3fffffff;

   // Header codes
   localparam logic [HDR_W-1:0] HDR_PUSH     = 2'd0;
   localparam logic [HDR_W-1:0] HDR_PRIM     = 2'd1;
   localparam logic [HDR_W-1:0] HDR_PUSH_NEG = 2'd2;
   localparam logic [HDR_W-1:0] HDR_PRIM_ALT = 2'd3;

   // Primitive codes
   localparam logic [PAYLOAD_W-1:0] PRIM_STOP = 30'd0;
   localparam logic [PAYLOAD_W-1:0] PRIM_ADD  = 30'd1;
   localparam logic [PAYLOAD_W-1:0] PRIM_SUB  = 30'd2;
   localparam logic [PAYLOAD_W-1:0] PRIM_MUL  = 30'd3;
   localparam logic [PAYLOAD_W-1:0] PRIM_DIV  = 30'd4;

   // Signed limits used by the divide check
   localparam logic [DATA_W-1:0] INT_MIN_VAL = 32'h80000000;
   localparam logic [DATA_W-1:0] ALL_ONES    = 32'hffffffff;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_OVERFLOW  = 3'd2,
      ST_DIV_ERR   = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } alu_op_type;

   // Command from the sequencer to the serial ALU
   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

endpackage : smx_pkg

`default_nettype wire

// ----- rtl/stack_machine_executor_top.sv -----
// Top level of the stack machine executor: sequencer, stack RAM and serial ALU.
//
// Usage:
//   Input channel req_*: one 32-bit instruction word per transaction, taken at
//   a rising edge with req_valid high and req_stall low. Result channel rsp_*:
//   one transaction per instruction carrying the new top of stack (0 when
//   empty), the stack depth, the halted flag and a status code.
//   Pushes, stop, unknown primitives and instructions rejected for underflow,
//   overflow or after stop go from acceptance straight to loading the result
//   register; a rejected divide (zero divisor, most negative over -1) first
//   reads the second operand from the stack RAM. Add, subtract, multiply and
//   divide read the second operand from the stack RAM, run in the bit-serial
//   ALU (one bit of the operands per cycle), finish and write back, then load
//   the result register. One instruction is in flight at a time and the
//   sequencer returns to idle between instructions.
//   The top of stack is held in a register; the stack RAM (one write port,
//   one registered read port) holds all entries.
//   Reset empties the stack and clears the halted flag; no clearing pass.
//   The result sits in an output register: the next instruction is accepted
//   while a result waits, and a finished result waits while a held result is stalled.
`default_nettype none

module stack_machine_executor_top
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic        [DATA_W-1:0] req_instr_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed      [DATA_W-1:0] rsp_top_value,
   output logic             [CNT_W-1:0]  rsp_stack_depth,
   output logic                          rsp_halted,
   output logic             [STATUS_W-1:0] rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_MAX = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] TWO       = CNT_W'(2);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CALC = 4'b0100,
      S_EMIT = 4'b1000
   } seq_state_type;

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              stopped_ff, stopped_in;
   logic [DATA_W-1:0] top_ff, top_in;
   status_type        status_ff, status_in;
   alu_op_type        op_ff, op_in;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_top_ff;
   logic [CNT_W-1:0]  rsp_depth_ff;
   logic              rsp_halted_ff;
   status_type        rsp_status_ff;

   logic [HDR_W-1:0]     hdr;
   logic [PAYLOAD_W-1:0] payload;
   logic [DATA_W-1:0]    push_val;
   logic [CNT_W-1:0]     below_top;
   logic                 out_free;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [DATA_W-1:0] rd_data;

   alu_ctrl_type      alu_ctrl;
   logic              alu_done;
   logic [DATA_W-1:0] alu_result;

   // Decode the instruction word
   assign hdr       = HDR_W'((req_instr_word & HDR_MASK) >> PAYLOAD_W);
   assign payload   = PAYLOAD_W'(req_instr_word & PAYLOAD_MASK);
   assign push_val  = hdr[1] ? DATA_W'(0) - {2'b00, payload} : {2'b00, payload};
   assign below_top = count_ff - TWO;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      stopped_in   = stopped_ff;
      top_in       = top_ff;
      status_in    = status_ff;
      op_in        = op_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = push_val;
      rd_en        = 1'b0;
      alu_ctrl.start = 1'b0;
      alu_ctrl.op    = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in  = S_EMIT;
               status_in = ST_OK;
               if (stopped_ff) begin
                  status_in = ST_IGNORED;
               end else begin
                  unique case (hdr)
                     HDR_PUSH, HDR_PUSH_NEG: begin
                        if (count_ff == DEPTH_MAX) begin
                           status_in = ST_OVERFLOW;
                        end else begin
                           wr_en    = 1'b1;
                           top_in   = push_val;
                           count_in = count_ff + 1'b1;
                        end
                     end
                     HDR_PRIM, HDR_PRIM_ALT: begin
                        priority if (payload == PRIM_STOP) begin
                           stopped_in = 1'b1;
                        end else if (payload <= PRIM_DIV) begin
                           if (count_ff < TWO) begin
                              status_in = ST_UNDERFLOW;
                           end else begin
                              // Fetch the entry under the top
                              rd_en    = 1'b1;
                              state_in = S_READ;
                              priority if (payload == PRIM_ADD) begin
                                 op_in = OP_ADD;
                              end else if (payload == PRIM_SUB) begin
                                 op_in = OP_SUB;
                              end else if (payload == PRIM_MUL) begin
                                 op_in = OP_MUL;
                              end else begin
                                 op_in = OP_DIV;
                              end
                           end
                        end else begin
                           status_in = ST_OK;
                        end
                     end
                     default: begin
                        status_in = ST_OK;
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            // Reject divide by zero and the most negative value over -1
            if (op_ff == OP_DIV &&
                (top_ff == '0 || (rd_data == INT_MIN_VAL && top_ff == ALL_ONES))) begin
               status_in = ST_DIV_ERR;
               state_in  = S_EMIT;
            end else begin
               alu_ctrl.start = 1'b1;
               state_in       = S_CALC;
            end
         end
         S_CALC: begin
            // Replace the two operands by the result
            if (alu_done) begin
               wr_en    = 1'b1;
               wr_addr  = below_top[AW-1:0];
               wr_data  = alu_result;
               top_in   = alu_result;
               count_in = count_ff - 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
      end
      top_ff    <= top_in;
      status_ff <= status_in;
      op_ff     <= op_in;
   end

   // Load the result register; drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_EMIT && out_free) begin
         rsp_top_ff    <= (count_ff == '0) ? '0 : top_ff;
         rsp_depth_ff  <= count_ff;
         rsp_halted_ff <= stopped_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = $signed(rsp_top_ff);
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_status      = rsp_status_ff;

   smx_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (below_top[AW-1:0]),
      .rd_data (rd_data)
   );

   smx_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opnd_a (rd_data),
      .opnd_b (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   // Once halted, the machine stays halted
   assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stack_machine_executor_top: halt flag cleared");

   // The ALU only runs with two operands on the stack
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> (count_ff >= TWO))
      else $error("stack_machine_executor_top: ALU running on short stack");

   // A finished ALU result only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      alu_done |-> (state_ff == S_CALC))
      else $error("stack_machine_executor_top: stray ALU result");

   // The depth moves by at most one entry per step
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == CNT_W'($past(count_ff) + 1'b1) ||
                         count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("stack_machine_executor_top: depth jumped");

endmodule : stack_machine_executor_top

`default_nettype wire

// ----- rtl/smx_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module smx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word into the registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : smx_ram

`default_nettype wire

// ----- rtl/smx_alu.sv -----
// Bit-serial ALU: add, subtract, shift-add multiply and restoring divide.
`default_nettype none

module smx_alu
   import smx_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire alu_ctrl_type      ctrl,
   input  wire logic [DATA_W-1:0] opnd_a,
   input  wire logic [DATA_W-1:0] opnd_b,
   output logic                   done,
   output logic      [DATA_W-1:0] result
);

   localparam int CNT_W = $clog2(DATA_W);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_W - 1);

   typedef enum logic [2:0] {
      AS_IDLE = 3'b001,
      AS_RUN  = 3'b010,
      AS_FIX  = 3'b100
   } alu_state_type;

   alu_state_type     state_ff, state_in;
   alu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              carry_ff, carry_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              bit_b;
   logic              bit_sum;
   logic              bit_cout;
   logic [DATA_W-1:0] trial;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] mag_a;
   logic [DATA_W-1:0] mag_b;

   // Serial adder cell on the low bits
   assign bit_b    = (op_ff == OP_SUB) ? ~b_ff[0] : b_ff[0];
   assign bit_sum  = a_ff[0] ^ bit_b ^ carry_ff;
   assign bit_cout = (a_ff[0] & bit_b) | (a_ff[0] & carry_ff) | (bit_b & carry_ff);

   // Restoring divide step: remainder shifted left with the next dividend bit
   assign trial = {acc_ff[DATA_W-2:0], a_ff[DATA_W-1]};
   assign diff  = {1'b0, trial} - {1'b0, b_ff};

   // Operand magnitudes for the divide
   assign mag_a = opnd_a[DATA_W-1] ? DATA_W'(0) - opnd_a : opnd_a;
   assign mag_b = opnd_b[DATA_W-1] ? DATA_W'(0) - opnd_b : opnd_b;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      carry_in = carry_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         AS_IDLE: begin
            // Load operands on a start command
            if (ctrl.start) begin
               state_in = AS_RUN;
               op_in    = ctrl.op;
               cnt_in   = '0;
               acc_in   = '0;
               carry_in = (ctrl.op == OP_SUB);
               neg_in   = opnd_a[DATA_W-1] ^ opnd_b[DATA_W-1];
               if (ctrl.op == OP_DIV) begin
                  a_in = mag_a;
                  b_in = mag_b;
               end else begin
                  a_in = opnd_a;
                  b_in = opnd_b;
               end
            end
         end
         AS_RUN: begin
            // Advance one bit per cycle
            unique case (op_ff)
               OP_ADD, OP_SUB: begin
                  acc_in   = {bit_sum, acc_ff[DATA_W-1:1]};
                  carry_in = bit_cout;
                  a_in     = a_ff >> 1;
                  b_in     = b_ff >> 1;
               end
               OP_MUL: begin
                  if (b_ff[0]) begin
                     acc_in = acc_ff + a_ff;
                  end
                  a_in = a_ff << 1;
                  b_in = b_ff >> 1;
               end
               OP_DIV: begin
                  if (!diff[DATA_W]) begin
                     acc_in = diff[DATA_W-1:0];
                  end else begin
                     acc_in = trial;
                  end
                  a_in = {a_ff[DATA_W-2:0], ~diff[DATA_W]};
               end
               default: begin
                  acc_in = acc_ff;
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_BIT) begin
               state_in = AS_FIX;
            end
         end
         AS_FIX: begin
            state_in = AS_IDLE;
         end
         default: begin
            state_in = AS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff    <= op_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      carry_ff <= carry_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
   end

   // Finish: the quotient in a_ff is negated when operand signs differ
   assign done   = (state_ff == AS_FIX);
   assign result = (op_ff != OP_DIV) ? acc_ff :
                   neg_ff            ? DATA_W'(0) - a_ff : a_ff;

   // A start only arrives while the unit is idle
   assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (state_ff == AS_IDLE))
      else $error("smx_alu: start while busy");

   // The finish state follows only the run step on the last bit of the word
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == AS_FIX) |-> ($past(state_ff) == AS_RUN && $past(cnt_ff) == LAST_BIT))
      else $error("smx_alu: finish without full bit count");

endmodule : smx_alu

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for stack_machine_executor_top with a shadow-stack scoreboard.
`default_nettype none

module tb;
   import smx_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int FILL_FIRST   = 700;
   localparam int FILL_LAST    = 960;
   localparam int QUIET_FIRST  = 1250;
   localparam int QUIET_LAST   = 1550;
   localparam int DRAIN_CYCLES = 60;

   // One expected result transaction: stack state after one instruction
   typedef struct {
      logic signed [DATA_W-1:0] top;
      logic        [8:0]        depth;
      logic                     halted;
      status_type               status;
   } stack_snapshot_type;

   // Shadow stack: predicts each instruction's result and checks what comes out
   class stack_scoreboard;
      logic [DATA_W-1:0] shadow_stack [STACK_DEPTH_DEF];
      int unsigned       shadow_depth;
      bit                shadow_halted;
      stack_snapshot_type pending_snapshots[$];
      int                errors;

      function new();
         shadow_depth  = 0;
         shadow_halted = 0;
         errors        = 0;
      endfunction

      function void note_instr(logic [DATA_W-1:0] word);
         logic [HDR_W-1:0]     hdr;
         logic [PAYLOAD_W-1:0] arg;
         logic [DATA_W-1:0]    a, b, r;
         status_type           st;
         bit                   ok;
         stack_snapshot_type   snap;
         hdr = word[DATA_W-1:PAYLOAD_W];
         arg = word[PAYLOAD_W-1:0];
         st  = ST_OK;
         r   = '0;
         ok  = 1;
         if (shadow_halted) begin
            st = ST_IGNORED;
         end else if (hdr == HDR_PUSH || hdr == HDR_PUSH_NEG) begin
            // push raw or negated payload unless full
            if (shadow_depth >= STACK_DEPTH_DEF) begin
               st = ST_OVERFLOW;
            end else begin
               shadow_stack[shadow_depth] = (hdr == HDR_PUSH_NEG) ?
                  32'd0 - {2'b00, arg} : {2'b00, arg};
               shadow_depth++;
            end
         end else if (arg == PRIM_STOP) begin
            shadow_halted = 1;
         end else if (arg <= PRIM_DIV) begin
            // pop two operands, push a op b
            if (shadow_depth < 2) begin
               st = ST_UNDERFLOW;
            end else begin
               a = shadow_stack[shadow_depth-2];
               b = shadow_stack[shadow_depth-1];
               case (arg)
                  PRIM_ADD: r = a + b;
                  PRIM_SUB: r = a - b;
                  PRIM_MUL: r = a * b;
                  default: begin
                     if (b == '0 || (a == INT_MIN_VAL && b == ALL_ONES))
                        ok = 0;
                     else
                        r = $signed(a) / $signed(b);
                  end
               endcase
               if (ok) begin
                  shadow_stack[shadow_depth-2] = r;
                  shadow_depth--;
               end else begin
                  st = ST_DIV_ERR;
               end
            end
         end
         snap.top    = (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
         snap.depth  = shadow_depth[8:0];
         snap.halted = shadow_halted;
         snap.status = st;
         pending_snapshots.push_back(snap);
      endfunction

      function void check_snapshot(logic signed [DATA_W-1:0] top, logic [8:0] depth,
                                   logic halted, logic [STATUS_W-1:0] status);
         stack_snapshot_type exp;
         if (pending_snapshots.size() == 0) begin
            $error("result transaction with no expected result waiting");
            errors++;
            return;
         end
         exp = pending_snapshots.pop_front();
         if (top !== exp.top) begin
            $error("top_value: expected %0d, actual %0d", exp.top, top);
            errors++;
         end
         if (depth !== exp.depth) begin
            $error("stack_depth: expected %0d, actual %0d", exp.depth, depth);
            errors++;
         end
         if (halted !== exp.halted) begin
            $error("halted: expected %0d, actual %0d", exp.halted, halted);
            errors++;
         end
         if (status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, status);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [DATA_W-1:0]      req_instr_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic signed [DATA_W-1:0] rsp_top_value;
   logic [8:0]             rsp_stack_depth;
   logic                   rsp_halted;
   logic [STATUS_W-1:0]    rsp_status;

   stack_scoreboard sb = new();
   bit              quiet = 0;
   int              cycle_count = 0;

   stack_machine_executor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_instr_word  (req_instr_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_depth (rsp_stack_depth),
      .rsp_halted      (rsp_halted),
      .rsp_status      (rsp_status)
   );

   // Clock: period 8
   initial clock = 0;
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Stall the result channel at random, except in the quiet stretch
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 12);
   end

   // Record accepted instructions, then check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0)
            sb.note_instr(req_instr_word);
         if (rsp_valid === 1'b1 && !rsp_stall)
            sb.check_snapshot(rsp_top_value, rsp_stack_depth, rsp_halted, rsp_status);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Present one instruction and hold it until accepted
   task automatic send_instr(input logic [DATA_W-1:0] word);
      while (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_instr_word <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   function automatic logic [PAYLOAD_W-1:0] rand_payload();
      case ($urandom_range(3))
         0:       return PAYLOAD_W'($urandom() & PAYLOAD_MASK);
         1:       return PAYLOAD_W'($urandom_range(9));
         2:       return PAYLOAD_W'($urandom_range(255));
         default: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return PAYLOAD_MASK[PAYLOAD_W-1:0];
               2:       return 30'd1;
               default: return 30'h20000000;
            endcase
         end
      endcase
   endfunction

   // Random instruction; bias toward pushes when shallow, operations when deep
   function automatic logic [DATA_W-1:0] pick_instr(int unsigned depth, bit fill);
      int                   roll;
      int                   push_pct;
      logic [HDR_W-1:0]     hdr;
      logic [PAYLOAD_W-1:0] arg;
      roll     = $urandom_range(99);
      push_pct = (depth < 4) ? 70 : (depth > 40) ? 25 : 50;
      if (fill || roll < push_pct) begin
         hdr = $urandom_range(1) ? HDR_PUSH_NEG : HDR_PUSH;
         arg = rand_payload();
      end else begin
         hdr = $urandom_range(1) ? HDR_PRIM_ALT : HDR_PRIM;
         if (roll < 95) begin
            case ($urandom_range(3))
               0:       arg = PRIM_ADD;
               1:       arg = PRIM_SUB;
               2:       arg = PRIM_MUL;
               default: arg = PRIM_DIV;
            endcase
         end else begin
            arg = PAYLOAD_W'($urandom_range(PAYLOAD_MASK, 5));
         end
      end
      return {hdr, arg};
   endfunction

   initial begin
      logic [DATA_W-1:0] prog[$];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_instr_word = '0;
      rsp_stall      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: underflow, limits, divide errors, unknown primitives
      prog.push_back({HDR_PRIM, PRIM_ADD});
      prog.push_back({HDR_PUSH, PAYLOAD_MASK[PAYLOAD_W-1:0]});
      prog.push_back({HDR_PRIM_ALT, PRIM_DIV});
      prog.push_back({HDR_PUSH, 30'd0});
      prog.push_back({HDR_PRIM, PRIM_DIV});
      prog.push_back({HDR_PRIM, PRIM_SUB});
      prog.push_back({HDR_PUSH_NEG, PAYLOAD_MASK[PAYLOAD_W-1:0]});
      prog.push_back({HDR_PRIM_ALT, PRIM_ADD});
      prog.push_back({HDR_PUSH_NEG, 30'h20000000});
      prog.push_back({HDR_PUSH, 30'd4});
      prog.push_back({HDR_PRIM_ALT, PRIM_MUL});
      prog.push_back({HDR_PUSH_NEG, 30'd1});
      prog.push_back({HDR_PRIM, PRIM_DIV});
      prog.push_back({HDR_PRIM_ALT, PRIM_SUB});
      prog.push_back({HDR_PUSH_NEG, 30'd0});
      prog.push_back({HDR_PRIM, 30'd5});
      prog.push_back({HDR_PRIM_ALT, PAYLOAD_MASK[PAYLOAD_W-1:0]});
      prog.push_back({HDR_PUSH, 30'd7});
      prog.push_back({HDR_PUSH_NEG, 30'd2});
      prog.push_back({HDR_PRIM_ALT, PRIM_DIV});
      prog.push_back({HDR_PUSH_NEG, 30'd9});
      prog.push_back({HDR_PRIM, PRIM_MUL});
      prog.push_back({HDR_PUSH, 30'h2aaaaaaa});
      prog.push_back({HDR_PRIM, PRIM_ADD});
      foreach (prog[i]) send_instr(prog[i]);

      // Random stream with one burst of pushes that runs past full
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
         send_instr(pick_instr(sb.shadow_depth, i >= FILL_FIRST && i < FILL_LAST));
      end
      quiet = 0;

      // Stop, then everything afterwards is ignored
      prog.delete();
      prog.push_back({HDR_PUSH, 30'd5});
      prog.push_back({HDR_PRIM, PRIM_STOP});
      prog.push_back({HDR_PUSH, 30'd9});
      prog.push_back({HDR_PRIM_ALT, PRIM_ADD});
      prog.push_back({HDR_PRIM_ALT, PRIM_STOP});
      prog.push_back({HDR_PUSH_NEG, 30'd3});
      prog.push_back({HDR_PRIM, 30'd77});
      foreach (prog[i]) send_instr(prog[i]);
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for strays
      while (sb.pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending_snapshots.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/smx_pkg.sv
rtl/smx_ram.sv
rtl/smx_alu.sv
rtl/stack_machine_executor_top.sv
tb/tb.sv
